// File: src/ritt_pkg.sv
// ritt_pkg: shared types and constants for radix_integer_to_text
// used by the controller, datapath and top level

package ritt_pkg;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd126;
    localparam int         DIV_BITS = 32;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load_item;   // capture input beat
        logic wr_sym;      // write alphabet from captured beat
        logic chk_start;   // reset check indices
        logic chk_eval;    // evaluate pair, advance
        logic div_start;   // load magnitude for a division pass
        logic div_step;    // one restoring step
        logic div_store;   // store remainder digit
        logic emit_rd;     // read alphabet for next digit
        logic emit_next;   // advance digit pointer
    } ritt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_load;
        logic pos_ok;
        logic radix_ok;
        logic chk_fail;
        logic chk_done;
        logic div_done;
        logic quot_zero;
        logic buf_full;
        logic neg;
        logic emit_last;
    } ritt_sts_t;

endpackage

// File: src/ritt_ram.sv
// ritt_ram: generic single-write, dual-read memory with registered read data
// no dependencies

module ritt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 95
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: src/ritt_datapath.sv
// ritt_datapath: alphabet store, pairwise check, restoring divider, digit store
// depends on ritt_pkg and ritt_ram

module ritt_datapath #(
    parameter int MAX_SYMBOLS = 95
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [6:0]           radix,
    input  logic [47:0]          in_data,
    input  ritt_pkg::ritt_cmd_t  cmd,
    output ritt_pkg::ritt_sts_t  sts,
    output logic [7:0]           char_out
);

    localparam int AW = $clog2(MAX_SYMBOLS);

    logic        op_reg;
    logic [6:0]  pos_reg;
    logic [7:0]  code_reg;
    logic [31:0] value_reg;

    logic [6:0]  i_reg, i_next, j_reg, j_next;
    logic        fail_reg, fail_next;
    logic [7:0]  ra, rb;

    logic [31:0] mag_reg, quot_reg;
    logic [6:0]  rem_reg;
    logic [5:0]  bit_reg;
    logic [5:0]  cnt_reg;
    logic [4:0]  rd_ptr_reg;
    logic [6:0]  dbuf [32];

    logic [AW-1:0] addr_a, addr_b;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg    <= in_data[0];
            pos_reg   <= in_data[7:1];
            code_reg  <= in_data[15:8];
            value_reg <= in_data[47:16];
        end
    end

    // check walks pairs (i, j): j == i checks printable, j > i checks unique
    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        fail_next = fail_reg;
        if (cmd.chk_start)
        begin
            i_next = '0;
            j_next = '0;
            fail_next = 1'b0;
        end
        else if (cmd.chk_eval)
        begin
            if (i_reg == j_reg)
            begin
                if (ra == ritt_pkg::CH_MINUS || ra == ritt_pkg::CH_PLUS ||
                    ra < ritt_pkg::PRINT_LO || ra > ritt_pkg::PRINT_HI)
                begin
                    fail_next = 1'b1;
                end
            end
            else if (ra == rb)
            begin
                fail_next = 1'b1;
            end
            if (j_reg + 7'd1 >= radix)
            begin
                i_next = i_reg + 7'd1;
                j_next = i_reg + 7'd1;
            end
            else
            begin
                j_next = j_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= '0;
            j_reg <= '0;
            fail_reg <= 1'b0;
        end
        else
        begin
            i_reg <= i_next;
            j_reg <= j_next;
            fail_reg <= fail_next;
        end
    end

    logic [31:0] mag_src;
    logic [6:0]  dig;
    assign dig = dbuf[rd_ptr_reg];

    // restoring division, one quotient bit per step
    logic [7:0] rem_sh;
    logic [7:0] rem_sub;
    assign rem_sh  = {rem_reg, quot_reg[31]};
    assign rem_sub = rem_sh - {1'b0, radix};
    assign mag_src = value_reg[31] ? (32'd0 - value_reg) : value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            bit_reg    <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (cmd.chk_start)
            begin
                cnt_reg <= '0;
            end
            if (cmd.div_start)
            begin
                bit_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                bit_reg <= bit_reg + 6'd1;
            end
            if (cmd.div_store)
            begin
                cnt_reg    <= cnt_reg + 6'd1;
                rd_ptr_reg <= cnt_reg[4:0];
            end
            else if (cmd.emit_next)
            begin
                rd_ptr_reg <= rd_ptr_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.chk_start)
        begin
            mag_reg <= mag_src;
        end
        if (cmd.div_start)
        begin
            quot_reg <= mag_reg;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!rem_sub[7])
            begin
                rem_reg  <= rem_sub[6:0];
                quot_reg <= {quot_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[6:0];
                quot_reg <= {quot_reg[30:0], 1'b0};
            end
        end
        if (cmd.div_store)
        begin
            dbuf[cnt_reg[4:0]] <= rem_reg;
            mag_reg <= quot_reg;
        end
    end

    always_comb
    begin
        addr_a = i_reg[AW-1:0];
        addr_b = j_reg[AW-1:0];
        if (cmd.emit_rd)
        begin
            addr_a = dig[AW-1:0];
        end
    end

    ritt_ram #(.WIDTH(8), .DEPTH(MAX_SYMBOLS)) u_alpha (
        .clk     (clk),
        .we      (cmd.wr_sym),
        .waddr   (pos_reg[AW-1:0]),
        .wdata   (code_reg),
        .raddr_a (addr_a),
        .rdata_a (ra),
        .raddr_b (addr_b),
        .rdata_b (rb)
    );

    assign char_out = ra;

    assign sts.is_load   = (op_reg == ritt_pkg::OP_LOAD);
    assign sts.pos_ok    = (pos_reg < 7'(MAX_SYMBOLS));
    assign sts.radix_ok  = (radix >= 7'd2) && (radix <= 7'(MAX_SYMBOLS));
    assign sts.chk_fail  = fail_reg;
    assign sts.chk_done  = (i_reg >= radix);
    assign sts.div_done  = (bit_reg == 6'(ritt_pkg::DIV_BITS));
    assign sts.quot_zero = (mag_reg == 32'd0);
    assign sts.buf_full  = (cnt_reg == 6'd32);
    assign sts.neg       = value_reg[31];
    assign sts.emit_last = (rd_ptr_reg == 5'd0);

endmodule

// File: src/ritt_ctrl.sv
// ritt_ctrl: sequencer for load, check, divide and emit phases
// depends on ritt_pkg

module ritt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic                m_tlast,
    output logic                sel_minus,
    output ritt_pkg::ritt_cmd_t cmd,
    input  ritt_pkg::ritt_sts_t sts
);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_DEC    = 11'b00000000010,
        ST_CRD    = 11'b00000000100,
        ST_CEV    = 11'b00000001000,
        ST_DSTART = 11'b00000010000,
        ST_DSTEP  = 11'b00000100000,
        ST_DSTORE = 11'b00001000000,
        ST_MINUS  = 11'b00010000000,
        ST_ERD    = 11'b00100000000,
        ST_EOUT   = 11'b01000000000,
        ST_CHK    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        m_tlast = 1'b0;
        sel_minus = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                if (sts.is_load)
                begin
                    cmd.wr_sym = sts.pos_ok;
                    state_next = ST_IDLE;
                end
                else if (!sts.radix_ok)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.chk_start = 1'b1;
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (sts.chk_fail)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.chk_done)
                begin
                    state_next = ST_DSTART;
                end
                else
                begin
                    state_next = ST_CRD;
                end
            end
            ST_CRD:
            begin
                state_next = ST_CEV;
            end
            ST_CEV:
            begin
                cmd.chk_eval = 1'b1;
                state_next = ST_CHK;
            end
            ST_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next = ST_DSTEP;
            end
            ST_DSTEP:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_DSTORE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_DSTORE:
            begin
                cmd.div_store = 1'b1;
                state_next = ST_MINUS;
            end
            ST_MINUS:
            begin
                // mag now holds quotient; loop until zero or buffer full
                if (!sts.quot_zero && !sts.buf_full)
                begin
                    state_next = ST_DSTART;
                end
                else if (sts.neg)
                begin
                    sel_minus = 1'b1;
                    m_tvalid = 1'b1;
                    if (m_tready)
                    begin
                        state_next = ST_ERD;
                    end
                end
                else
                begin
                    state_next = ST_ERD;
                end
            end
            ST_ERD:
            begin
                cmd.emit_rd = 1'b1;
                state_next = ST_EOUT;
            end
            ST_EOUT:
            begin
                // keep the read address on the digit so the char holds while stalled
                cmd.emit_rd = 1'b1;
                m_tvalid = 1'b1;
                m_tlast = sts.emit_last;
                if (m_tready)
                begin
                    if (sts.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.emit_next = 1'b1;
                        state_next = ST_ERD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/radix_integer_to_text.sv
// radix_integer_to_text: top level joining controller, datapath and config register
// depends on ritt_pkg, ritt_ctrl, ritt_datapath, ritt_ram

// A load beat writes one alphabet symbol. A convert beat passes a decode state,
// then checks the first radix symbols pairwise through the alphabet memory's
// two read ports, over radix*(radix+1)/2 pairs, then runs a restoring divider
// for up to 32 digits, and emits an optional minus sign and the digits, each
// character through a read state and an output state plus any output stall,
// most significant first, with tlast on the final one. A new input beat is
// taken only once the previous item is finished. The radix register resets
// to 10 and is written through cfg_valid/cfg_ready.

module radix_integer_to_text #(
    parameter int MAX_SYMBOLS = 95
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // symbol_pos[6:0], symbol_code[14:7], value[46:15], zero [47]
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // char_out[7:0]
    output logic        m_tlast,   // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data   // radix
);

    logic [6:0] radix_reg;
    logic [7:0] dp_char;
    logic       sel_minus;
    logic [47:0] in_data;
    ritt_pkg::ritt_cmd_t cmd;
    ritt_pkg::ritt_sts_t sts;

    assign cfg_ready = 1'b1;
    assign in_data = {s_tdata[46:0], s_tuser};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= 7'd10;
        end
        else if (cfg_valid)
        begin
            radix_reg <= cfg_data;
        end
    end

    ritt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tlast   (m_tlast),
        .sel_minus (sel_minus),
        .cmd       (cmd),
        .sts       (sts)
    );

    ritt_datapath #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .radix    (radix_reg),
        .in_data  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .char_out (dp_char)
    );

    assign m_tdata = sel_minus ? ritt_pkg::CH_MINUS : dp_char;

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && sel_minus) |-> !m_tlast)
        else $error("minus sign flagged last");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input accepted during emit");

    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output changed while stalled");

endmodule

// File: bench/tb.sv
// tb: self-checking bench for radix_integer_to_text, signed integer to text in a set radix
// depends on ritt_pkg and the radix_integer_to_text RTL; predicts every character beat itself
`timescale 1ns / 1ps

module tb;

    localparam int NUM_SYMBOLS = 95;
    localparam int NUM_DIGITS  = 32;
    localparam int QUIET_WAIT  = 20000;     // worst check walk plus division and emit
    localparam int CYCLE_LIMIT = 6000000;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } text_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data = 7'd10;

    // predictor state
    logic [7:0]  sym_tab [NUM_SYMBOLS];
    logic [7:0]  good_sym [NUM_SYMBOLS];
    logic [6:0]  cur_radix;
    text_beat_t  pending_text [$];

    int mismatches = 0;
    int cycles = 0;
    int burst_left = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int stall_left = 0;

    radix_integer_to_text uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // receiver: long hold-off on request, otherwise a changing stall pattern
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready = 1'b0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(10, 200);
            end
            else
                stall_left--;
            case (stall_mode)
                0: m_tready = 1'b1;
                1: m_tready = ($urandom_range(0, 3) != 0);
                2: m_tready = ~m_tready;
                default: m_tready = 1'($urandom_range(0, 1));
            endcase
        end
    end

    // check each character beat against the oldest expectation
    always @(posedge clk)
    begin
        text_beat_t exp_beat;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_text.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: char %h last %b", m_tdata, m_tlast);
            end
            else
            begin
                exp_beat = pending_text.pop_front();
                if (m_tdata !== exp_beat.ch || m_tlast !== exp_beat.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected char %h last %b, got char %h last %b",
                                 exp_beat.ch, exp_beat.last, m_tdata, m_tlast);
                end
            end
        end
    end

    function automatic bit alphabet_valid(input int n);
        if (n < 2 || n > NUM_SYMBOLS)
            return 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (sym_tab[i] == ritt_pkg::CH_MINUS || sym_tab[i] == ritt_pkg::CH_PLUS ||
                sym_tab[i] < ritt_pkg::PRINT_LO || sym_tab[i] > ritt_pkg::PRINT_HI)
                return 1'b0;
            for (int j = i + 1; j < n; j++)
                if (sym_tab[j] == sym_tab[i])
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_text(input logic [31:0] value);
        logic [31:0] mag;
        logic [6:0]  digit [NUM_DIGITS];
        int          count;
        text_beat_t  beat;
        if (!alphabet_valid(int'(cur_radix)))
            return;
        // most negative value: two's complement negate wraps to 2^31, still right
        mag = value[31] ? -value : value;
        count = 0;
        do
        begin
            digit[count] = 7'(mag % cur_radix);
            count++;
            mag = mag / cur_radix;
        end while (mag != 0 && count < NUM_DIGITS);
        if (value[31])
        begin
            beat.ch = ritt_pkg::CH_MINUS;
            beat.last = 1'b0;
            pending_text.push_back(beat);
        end
        for (int k = count; k > 0; k--)
        begin
            beat.ch = sym_tab[digit[k - 1]];
            beat.last = (k == 1);
            pending_text.push_back(beat);
        end
    endfunction

    task automatic send_item(input logic op, input logic [6:0] pos, input logic [7:0] code,
                             input logic [31:0] value);
        int gap;
        @(negedge clk);
        s_tdata = {1'b0, value, code, pos};
        s_tuser = op;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        if (op == ritt_pkg::OP_LOAD)
        begin
            if (pos < NUM_SYMBOLS)
                sym_tab[pos] = code;
        end
        else
            predict_text(value);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    task automatic load_sym(input logic [6:0] pos, input logic [7:0] code);
        send_item(ritt_pkg::OP_LOAD, pos, code, $urandom);
    endtask

    task automatic convert(input logic [31:0] value);
        send_item(ritt_pkg::OP_CONVERT, 7'($urandom), 8'($urandom), value);
    endtask

    // let everything drain, including work on a convert that emits nothing
    task automatic settle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_text.size() != 0)
            @(posedge clk);
        repeat (QUIET_WAIT) @(posedge clk);
    endtask

    task automatic set_radix(input logic [6:0] r);
        settle();
        @(negedge clk);
        cfg_data = r;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cur_radix = r;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic test_load_alphabet();
        int n;
        n = 0;
        // digits first, then letters and punctuation, skipping the sign characters
        for (int c = 48; c < 127 + 16; c++)
        begin
            int ch;
            ch = (c <= 126) ? c : c - 95;
            if (ch != ritt_pkg::CH_PLUS && ch != ritt_pkg::CH_MINUS && n < 93)
            begin
                good_sym[n] = 8'(ch);
                n++;
            end
        end
        good_sym[93] = good_sym[0];   // duplicate at the top end
        good_sym[94] = 8'd0;          // unprintable
        for (int p = 0; p < NUM_SYMBOLS; p++)
            load_sym(7'(p), good_sym[p]);
    endtask

    task automatic test_default_radix();
        convert(32'd0);
        convert(32'd7);
        convert(32'hffffffff);
        convert(32'h7fffffff);
        convert(32'h80000000);
        convert(-32'sd1234);
    endtask

    task automatic test_radix_extremes();
        set_radix(7'd2);
        convert(32'h80000000);
        convert(32'h7fffffff);
        convert(32'hffffffff);
        convert(32'd0);
        set_radix(7'd93);
        convert(32'h80000000);
        convert(32'd92);
        convert(32'd0);
        set_radix(7'd95);
        convert(32'd5);
        set_radix(7'd94);
        convert(32'd5);
        set_radix(7'd0);
        convert(32'd5);
        set_radix(7'd1);
        convert(32'd5);
        set_radix(7'd10);
    endtask

    task automatic test_bad_alphabet();
        load_sym(7'd3, ritt_pkg::CH_PLUS);
        convert(32'd33);
        load_sym(7'd3, ritt_pkg::CH_MINUS);
        convert(32'd33);
        load_sym(7'd3, 8'd31);
        convert(32'd33);
        load_sym(7'd3, 8'd127);
        convert(32'd33);
        load_sym(7'd3, good_sym[5]);
        convert(32'd33);
        load_sym(7'd3, good_sym[3]);
        load_sym(7'd100, 8'hff);     // out of range, ignored
        load_sym(7'd127, 8'h00);
        convert(32'd33);
    endtask

    task automatic test_backpressure();
        set_radix(7'd2);
        hold_left = 4000;
        for (int i = 0; i < 6; i++)
            convert($urandom);
    endtask

    task automatic test_random(input int count);
        int kind;
        int p;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 15);
            if (kind < 11)
            begin
                if ($urandom_range(0, 3) == 0)
                    convert($urandom_range(0, 600) - 300);
                else
                    convert($urandom);
            end
            else if (kind < 13)
                load_sym(7'($urandom_range(95, 127)), 8'($urandom));
            else if (kind < 15)
            begin
                p = $urandom_range(0, 94);
                load_sym(7'(p), good_sym[p]);
            end
            else
            begin
                // break one used symbol, try a convert, then repair it
                p = $urandom_range(0, cur_radix - 1);
                load_sym(7'(p), 8'($urandom));
                convert($urandom);
                load_sym(7'(p), good_sym[p]);
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < NUM_SYMBOLS; i++)
            sym_tab[i] = 8'd0;
        cur_radix = 7'd10;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_load_alphabet();
        test_default_radix();
        test_radix_extremes();
        test_bad_alphabet();
        test_backpressure();
        set_radix(7'd16);
        test_random(25);
        set_radix(7'd36);
        test_random(25);
        set_radix(7'd2);
        test_random(20);
        set_radix(7'($urandom_range(3, 20)));
        test_random(30);
        set_radix(7'd10);
        test_random(25);

        settle();
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
